// ===== src/bcfd_pkg.sv =====
// shared widths, command struct and constants for the bezier forward difference core
package bcfd_pkg;

    // fixed point formats
    localparam int COORD_FRAC_BITS = 16;
    localparam int ACCUM_FRAC_BITS = 32;
    localparam int FRAC_SHIFT      = ACCUM_FRAC_BITS - COORD_FRAC_BITS;
    localparam int COORD_W         = 32;
    localparam int ACC_W           = 64;

    // segment count and its powers
    localparam int N_W             = 6;
    localparam int N2_W            = 2 * N_W;
    localparam int N3_W            = 3 * N_W;
    localparam logic [N_W-1:0] SEG_RESET = N_W'(16);

    // coefficient and numerator widths
    localparam int COEF_W          = COORD_W + 6;
    localparam int NUM_W           = COEF_W + N2_W + 2;

    // long divider, four quotient bits per cycle
    localparam int DIV_RADIX_BITS  = 4;
    localparam int DIVD_W          = ((NUM_W + FRAC_SHIFT + DIV_RADIX_BITS - 1)
                                      / DIV_RADIX_BITS) * DIV_RADIX_BITS;
    localparam int DIV_STEPS       = DIVD_W / DIV_RADIX_BITS;
    localparam int ITER_W          = $clog2(DIV_STEPS);

    // which difference a division produces
    localparam logic [1:0] SEL_D1  = 2'd0;
    localparam logic [1:0] SEL_D2  = 2'd1;
    localparam logic [1:0] SEL_D3  = 2'd2;

    // commands from the controller to the axis lanes
    typedef struct packed {
        logic       capture;
        logic       mul;
        logic       sum;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic [1:0] div_sel;
        logic       advance;
    } cmd_t;

endpackage

// ===== src/bcfd_div.sv =====
// signed floor divider of a scaled numerator by n cubed, four bits per cycle while step is high
module bcfd_div
(
    input  logic                                clk,
    input  logic                                load,
    input  logic                                step,
    input  logic signed [bcfd_pkg::NUM_W-1:0]   numer,
    input  logic        [bcfd_pkg::N3_W-1:0]    denom,
    output logic        [bcfd_pkg::ACC_W-1:0]   quot
);

    logic                               neg_reg;
    logic [bcfd_pkg::DIVD_W-1:0]        dvd_reg;
    logic [bcfd_pkg::DIVD_W-1:0]        dvd_next;
    logic [bcfd_pkg::N3_W-1:0]          rem_reg;
    logic [bcfd_pkg::N3_W-1:0]          rem_next;
    logic [bcfd_pkg::NUM_W-1:0]         mag;
    logic [bcfd_pkg::ACC_W-1:0]         q0;
    logic [bcfd_pkg::ACC_W-1:0]         q_neg;

    // magnitude of the numerator
    assign mag = numer[bcfd_pkg::NUM_W-1] ? bcfd_pkg::NUM_W'(-numer)
                                          : bcfd_pkg::NUM_W'(numer);

    // four restoring steps per cycle
    always_comb
    begin
        logic [bcfd_pkg::N3_W:0]        trial;
        logic [bcfd_pkg::N3_W-1:0]      rem_v;
        logic [bcfd_pkg::DIVD_W-1:0]    dvd_v;
        rem_v = rem_reg;
        dvd_v = dvd_reg;
        trial = '0;
        for (int i = 0; i < bcfd_pkg::DIV_RADIX_BITS; i++)
        begin
            trial = {rem_v, dvd_v[bcfd_pkg::DIVD_W-1]};
            dvd_v = {dvd_v[bcfd_pkg::DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, denom})
            begin
                trial    = trial - {1'b0, denom};
                dvd_v[0] = 1'b1;
            end
            rem_v = trial[bcfd_pkg::N3_W-1:0];
        end
        rem_next = rem_v;
        dvd_next = dvd_v;
    end

    // shift register holds dividend, then quotient
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= numer[bcfd_pkg::NUM_W-1];
            dvd_reg <= bcfd_pkg::DIVD_W'({mag, {bcfd_pkg::FRAC_SHIFT{1'b0}}});
            rem_reg <= '0;
        end
        else if (step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    // round toward minus infinity for negative numerators
    assign q0    = dvd_reg[bcfd_pkg::ACC_W-1:0];
    assign q_neg = bcfd_pkg::ACC_W'(0) - (q0 + bcfd_pkg::ACC_W'(|rem_reg));
    assign quot  = neg_reg ? q_neg : q0;

endmodule

// ===== src/bcfd_lane.sv =====
// one axis: coefficients, difference setup and forward difference accumulator
module bcfd_lane
(
    input  logic                                clk,
    input  bcfd_pkg::cmd_t                      cmd,
    input  logic        [bcfd_pkg::N_W-1:0]     n_val,
    input  logic        [bcfd_pkg::N2_W-1:0]    n2_val,
    input  logic        [bcfd_pkg::N3_W-1:0]    n3_val,
    input  logic signed [bcfd_pkg::COORD_W-1:0] p0,
    input  logic signed [bcfd_pkg::COORD_W-1:0] p1,
    input  logic signed [bcfd_pkg::COORD_W-1:0] p2,
    input  logic signed [bcfd_pkg::COORD_W-1:0] p3,
    output logic signed [bcfd_pkg::COORD_W-1:0] point
);

    logic signed [bcfd_pkg::COEF_W-1:0] e0, e1, e2, e3;
    logic signed [bcfd_pkg::COEF_W-1:0] d30, d12, d10, sb;
    logic signed [bcfd_pkg::COEF_W-1:0] a_next, b_next, c_next;
    logic signed [bcfd_pkg::COEF_W-1:0] a_reg, b_reg, c_reg;
    logic signed [bcfd_pkg::NUM_W-1:0]  a_ext, n_ext, n2_ext;
    logic signed [bcfd_pkg::NUM_W-1:0]  bn_reg, cn2_reg;
    logic signed [bcfd_pkg::NUM_W-1:0]  a6;
    logic signed [bcfd_pkg::NUM_W-1:0]  num1_reg, num2_reg, num3_reg;
    logic signed [bcfd_pkg::NUM_W-1:0]  div_num;
    logic        [bcfd_pkg::ACC_W-1:0]  quot;
    logic        [bcfd_pkg::ACC_W-1:0]  acc_reg, d1_reg, d2_reg, d3_reg;

    // power basis coefficients from the control points
    assign e0     = bcfd_pkg::COEF_W'(p0);
    assign e1     = bcfd_pkg::COEF_W'(p1);
    assign e2     = bcfd_pkg::COEF_W'(p2);
    assign e3     = bcfd_pkg::COEF_W'(p3);
    assign d30    = e3 - e0;
    assign d12    = e1 - e2;
    assign d10    = e1 - e0;
    assign sb     = e0 - (e1 <<< 1) + e2;
    assign a_next = d30 + d12 + (d12 <<< 1);
    assign b_next = sb + (sb <<< 1);
    assign c_next = d10 + (d10 <<< 1);

    // operands for the numerator products
    assign a_ext  = bcfd_pkg::NUM_W'(a_reg);
    assign n_ext  = bcfd_pkg::NUM_W'({1'b0, n_val});
    assign n2_ext = bcfd_pkg::NUM_W'({1'b0, n2_val});
    assign a6     = (a_ext <<< 2) + (a_ext <<< 1);

    // numerator picked for the current division
    always_comb
    begin
        case (cmd.div_sel)
            bcfd_pkg::SEL_D1: div_num = num1_reg;
            bcfd_pkg::SEL_D2: div_num = num2_reg;
            default:          div_num = num3_reg;
        endcase
    end

    bcfd_div u_div
    (
        .clk   (clk),
        .load  (cmd.div_load),
        .step  (cmd.div_step),
        .numer (div_num),
        .denom (n3_val),
        .quot  (quot)
    );

    // coefficient, product and numerator registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
        if (cmd.mul)
        begin
            bn_reg  <= bcfd_pkg::NUM_W'(b_reg) * n_ext;
            cn2_reg <= bcfd_pkg::NUM_W'(c_reg) * n2_ext;
        end
        if (cmd.sum)
        begin
            num1_reg <= a_ext + bn_reg + cn2_reg;
            num2_reg <= a6 + (bn_reg <<< 1);
            num3_reg <= a6;
        end
    end

    // accumulator and differences
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            acc_reg <= bcfd_pkg::ACC_W'(p0) << bcfd_pkg::FRAC_SHIFT;
        end
        else if (cmd.advance)
        begin
            acc_reg <= acc_reg + d1_reg;
            d1_reg  <= d1_reg + d2_reg;
            d2_reg  <= d2_reg + d3_reg;
        end
        else if (cmd.div_store)
        begin
            case (cmd.div_sel)
                bcfd_pkg::SEL_D1: d1_reg <= quot;
                bcfd_pkg::SEL_D2: d2_reg <= quot;
                default:          d3_reg <= quot;
            endcase
        end
    end

    // truncate accumulator to the coordinate format
    assign point = acc_reg[bcfd_pkg::FRAC_SHIFT+bcfd_pkg::COORD_W-1:bcfd_pkg::FRAC_SHIFT];

endmodule

// ===== src/bcfd_ctrl.sv =====
// sequencer: setup, three divisions per axis and point emission
module bcfd_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [bcfd_pkg::N_W-1:0]        cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bcfd_pkg::cmd_t                  cmd,
    output logic [bcfd_pkg::N_W-1:0]        n_val,
    output logic [bcfd_pkg::N2_W-1:0]       n2_val,
    output logic [bcfd_pkg::N3_W-1:0]       n3_val,
    output logic [bcfd_pkg::N_W-1:0]        step_index,
    output logic                            last_point
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQ     = 3'd1;
    localparam logic [2:0] ST_CUBE   = 3'd2;
    localparam logic [2:0] ST_NUM    = 3'd3;
    localparam logic [2:0] ST_DLOAD  = 3'd4;
    localparam logic [2:0] ST_DSTEP  = 3'd5;
    localparam logic [2:0] ST_DSTORE = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0]                     state_reg, state_next;
    logic [bcfd_pkg::N_W-1:0]       seg_reg;
    logic [bcfd_pkg::N_W-1:0]       n_reg, n_next;
    logic [bcfd_pkg::N2_W-1:0]      n2_reg, n2_next;
    logic [bcfd_pkg::N3_W-1:0]      n3_reg, n3_next;
    logic [bcfd_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic [1:0]                     sel_reg, sel_next;
    logic [bcfd_pkg::N_W-1:0]       step_reg, step_next;
    logic                           in_xact;
    logic                           out_xact;
    logic                           last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_xact   = in_valid && !in_stall;
    assign out_xact  = out_valid && !out_stall;
    assign last      = (step_reg == n_reg);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        n2_next    = n2_reg;
        n3_next    = n3_reg;
        iter_next  = iter_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    cmd.capture = 1'b1;
                    n_next      = (seg_reg == '0) ? bcfd_pkg::N_W'(1) : seg_reg;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                n2_next    = bcfd_pkg::N2_W'(n_reg) * bcfd_pkg::N2_W'(n_reg);
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                n3_next    = bcfd_pkg::N3_W'(n2_reg) * bcfd_pkg::N3_W'(n_reg);
                cmd.mul    = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.sum    = 1'b1;
                sel_next   = bcfd_pkg::SEL_D1;
                state_next = ST_DLOAD;
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                iter_next    = '0;
                state_next   = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == bcfd_pkg::ITER_W'(bcfd_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE:
            begin
                cmd.div_store = 1'b1;
                if (sel_reg == bcfd_pkg::SEL_D3)
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_DLOAD;
                end
            end
            ST_EMIT:
            begin
                if (out_xact)
                begin
                    cmd.advance = 1'b1;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= bcfd_pkg::SEG_RESET;
            n_reg     <= '0;
            n2_reg    <= '0;
            n3_reg    <= '0;
            iter_reg  <= '0;
            sel_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                seg_reg <= cfg_wr_data;
            end
            n_reg    <= n_next;
            n2_reg   <= n2_next;
            n3_reg   <= n3_next;
            iter_reg <= iter_next;
            sel_reg  <= sel_next;
            step_reg <= step_next;
        end
    end

    assign n_val      = n_reg;
    assign n2_val     = n2_reg;
    assign n3_val     = n3_reg;
    assign step_index = step_reg;
    assign last_point = last;

endmodule

// ===== src/bezier_curve_forward_difference_core.sv =====
// cubic bezier tessellation by forward differencing, one curve per transaction
// after the input transaction the sequencer runs its setup states (square, cube, numerators),
//   then three divisions (load, steps, store) in each axis lane's own divider, then emits points
// one curve at a time: n + 1 points, n = segments; points at one per cycle while out_stall is low
// reset: asynchronous active low; idle, segments back to 16
module bezier_curve_forward_difference_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic        [bcfd_pkg::N_W-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [bcfd_pkg::COORD_W-1:0] start_x,
    input  logic signed [bcfd_pkg::COORD_W-1:0] start_y,
    input  logic signed [bcfd_pkg::COORD_W-1:0] start_z,
    input  logic signed [bcfd_pkg::COORD_W-1:0] near_x,
    input  logic signed [bcfd_pkg::COORD_W-1:0] near_y,
    input  logic signed [bcfd_pkg::COORD_W-1:0] near_z,
    input  logic signed [bcfd_pkg::COORD_W-1:0] far_x,
    input  logic signed [bcfd_pkg::COORD_W-1:0] far_y,
    input  logic signed [bcfd_pkg::COORD_W-1:0] far_z,
    input  logic signed [bcfd_pkg::COORD_W-1:0] end_x,
    input  logic signed [bcfd_pkg::COORD_W-1:0] end_y,
    input  logic signed [bcfd_pkg::COORD_W-1:0] end_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bcfd_pkg::COORD_W-1:0] point_x,
    output logic signed [bcfd_pkg::COORD_W-1:0] point_y,
    output logic signed [bcfd_pkg::COORD_W-1:0] point_z,
    output logic        [bcfd_pkg::N_W-1:0]     step_index,
    output logic                                last_point
);

    bcfd_pkg::cmd_t                 cmd;
    logic [bcfd_pkg::N_W-1:0]       n_val;
    logic [bcfd_pkg::N2_W-1:0]      n2_val;
    logic [bcfd_pkg::N3_W-1:0]      n3_val;

    // sequencer
    bcfd_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .n_val       (n_val),
        .n2_val      (n2_val),
        .n3_val      (n3_val),
        .step_index  (step_index),
        .last_point  (last_point)
    );

    // one lane per axis
    bcfd_lane u_lane_x
    (
        .clk    (clk),
        .cmd    (cmd),
        .n_val  (n_val),
        .n2_val (n2_val),
        .n3_val (n3_val),
        .p0     (start_x),
        .p1     (near_x),
        .p2     (far_x),
        .p3     (end_x),
        .point  (point_x)
    );

    bcfd_lane u_lane_y
    (
        .clk    (clk),
        .cmd    (cmd),
        .n_val  (n_val),
        .n2_val (n2_val),
        .n3_val (n3_val),
        .p0     (start_y),
        .p1     (near_y),
        .p2     (far_y),
        .p3     (end_y),
        .point  (point_y)
    );

    bcfd_lane u_lane_z
    (
        .clk    (clk),
        .cmd    (cmd),
        .n_val  (n_val),
        .n2_val (n2_val),
        .n3_val (n3_val),
        .p0     (start_z),
        .p1     (near_z),
        .p2     (far_z),
        .p3     (end_z),
        .point  (point_z)
    );

endmodule

// ===== src/bcfd_checker.sv =====
// port level checks for the bezier forward difference core, with its bind
module bcfd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [bcfd_pkg::COORD_W-1:0] point_x,
    input  logic        [bcfd_pkg::N_W-1:0]     step_index,
    input  logic                                last_point
);

    // a stalled point holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(step_index))
        else $error("stalled point changed");

    // no curve is taken while points are still going out
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
        else $error("input transaction during emission");

    // points of one curve follow each other with rising index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_point
        |=> out_valid && (step_index == $past(step_index) + 1'b1))
        else $error("point sequence broken");

    // the final point closes the curve
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_point |=> !out_valid)
        else $error("point after last point");

    // an accepted curve starts at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> step_index == '0)
        else $error("curve did not start at index zero");

endmodule

bind bezier_curve_forward_difference_core bcfd_checker u_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench for the cubic bezier forward difference core
`timescale 1ns / 1ps

typedef logic signed [bcfd_pkg::COORD_W-1:0] coord_t;

// one curve: four control points, three axes each
typedef struct {
    coord_t ctrl[4][3];
} curve_t;

// one tessellated point as seen on the output port
typedef struct packed {
    logic signed [bcfd_pkg::COORD_W-1:0] x;
    logic signed [bcfd_pkg::COORD_W-1:0] y;
    logic signed [bcfd_pkg::COORD_W-1:0] z;
    logic        [bcfd_pkg::N_W-1:0]     index;
    logic                                last;
} point_t;

// predicts the points of each curve and checks them in order
class curve_point_scoreboard;
    logic [bcfd_pkg::N_W-1:0] segments;
    logic [63:0]              acc[3];
    logic [63:0]              fd1[3];
    logic [63:0]              fd2[3];
    logic [63:0]              fd3[3];
    point_t                   expected_points[$];
    int                       errors;
    int                       curves;
    int                       points;

    function new();
        segments = bcfd_pkg::SEG_RESET;
        errors   = 0;
        curves   = 0;
        points   = 0;
    endfunction

    // floor(num * 2^shift / den), low 64 bits kept
    function logic [63:0] floor_scaled(longint num, longint den);
        logic signed [127:0] wide;
        logic signed [127:0] dvs;
        logic signed [127:0] quo;
        logic signed [127:0] rem;
        wide = num;
        wide = wide <<< bcfd_pkg::FRAC_SHIFT;
        dvs  = den;
        quo  = wide / dvs;
        rem  = wide % dvs;
        if (rem != 0 && wide < 0)
            quo = quo - 1;
        return quo[63:0];
    endfunction

    function point_t current_point(int idx, longint n);
        point_t pt;
        pt.x     = coord_t'(acc[0] >> bcfd_pkg::FRAC_SHIFT);
        pt.y     = coord_t'(acc[1] >> bcfd_pkg::FRAC_SHIFT);
        pt.z     = coord_t'(acc[2] >> bcfd_pkg::FRAC_SHIFT);
        pt.index = bcfd_pkg::N_W'(idx);
        pt.last  = (idx == n);
        return pt;
    endfunction

    // accepted curve: set up differences and queue all its points
    function void note_curve(curve_t cv);
        longint n;
        longint n3;
        longint p0, p1, p2, p3;
        longint ca, cb, cc;
        n  = (segments == 0) ? 1 : longint'(segments);
        n3 = n * n * n;
        for (int j = 0; j < 3; j++)
        begin
            p0 = cv.ctrl[0][j];
            p1 = cv.ctrl[1][j];
            p2 = cv.ctrl[2][j];
            p3 = cv.ctrl[3][j];
            ca = (p3 - p0) + 3 * (p1 - p2);
            cb = 3 * (p0 - 2 * p1 + p2);
            cc = 3 * (p1 - p0);
            acc[j] = 64'(p0) << bcfd_pkg::FRAC_SHIFT;
            fd1[j] = floor_scaled(ca + cb * n + cc * n * n, n3);
            fd2[j] = floor_scaled(6 * ca + 2 * cb * n, n3);
            fd3[j] = floor_scaled(6 * ca, n3);
        end
        expected_points = {expected_points, current_point(0, n)};
        for (int i = 1; i <= n; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                acc[j] = acc[j] + fd1[j];
                fd1[j] = fd1[j] + fd2[j];
                fd2[j] = fd2[j] + fd3[j];
            end
            expected_points = {expected_points, current_point(i, n)};
        end
        curves++;
    endfunction

    // compare one accepted point with the oldest prediction
    function void check_point(point_t got);
        point_t      want;
        logic [31:0] wv[5];
        logic [31:0] gv[5];
        string       names[5];
        if (expected_points.size() == 0)
        begin
            $display("%0t: unexpected point x=%h y=%h z=%h index=%0d last=%0d",
                     $time, got.x, got.y, got.z, got.index, got.last);
            errors++;
            return;
        end
        want  = expected_points.pop_front();
        names = '{"point_x", "point_y", "point_z", "step_index", "last_point"};
        wv    = '{want.x, want.y, want.z, 32'(want.index), 32'(want.last)};
        gv    = '{got.x, got.y, got.z, 32'(got.index), 32'(got.last)};
        for (int f = 0; f < 5; f++)
        begin
            if (wv[f] !== gv[f])
            begin
                $display("%0t: %s mismatch, expected %h actual %h",
                         $time, names[f], wv[f], gv[f]);
                errors++;
            end
        end
        points++;
    endfunction

    function int pending();
        return expected_points.size();
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int ITEMS_PER_SET = 35;
    localparam int NUM_SETS      = 10;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [bcfd_pkg::N_W-1:0]   cfg_wr_data;
    logic                       in_valid;
    logic                       in_stall;
    coord_t                     start_x, start_y, start_z;
    coord_t                     near_x, near_y, near_z;
    coord_t                     far_x, far_y, far_z;
    coord_t                     end_x, end_y, end_z;
    logic                       out_valid;
    logic                       out_stall;
    coord_t                     point_x, point_y, point_z;
    logic [bcfd_pkg::N_W-1:0]   step_index;
    logic                       last_point;

    curve_point_scoreboard   sb = new();
    logic                    tx_quiet;
    logic                    rx_quiet;
    int                      rx_hold;
    int                      cycle_count;
    int                      settings_used;

    bezier_curve_forward_difference_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_x     (start_x),
        .start_y     (start_y),
        .start_z     (start_z),
        .near_x      (near_x),
        .near_y      (near_y),
        .near_z      (near_z),
        .far_x       (far_x),
        .far_y       (far_y),
        .far_z       (far_z),
        .end_x       (end_x),
        .end_y       (end_y),
        .end_z       (end_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .step_index  (step_index),
        .last_point  (last_point)
    );

    // clock
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_stall = 1'b1;
            rx_hold--;
        end
        else
        begin
            rx_hold   = pick_gap(rx_quiet);
            out_stall = (rx_hold > 0);
            if (rx_hold > 0)
                rx_hold--;
        end
    end

    // check each point transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_point('{x: point_x, y: point_y, z: point_z,
                             index: step_index, last: last_point});
    end

    // coordinate mix: full range, small, extremes and near extremes
    function automatic coord_t rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return coord_t'($urandom);
        if (r < 70)
            return coord_t'($urandom_range(0, 32'h0020_0000)) - coord_t'(32'h0010_0000);
        if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return coord_t'(32'h7FFF_FFFF);
                1:       return coord_t'(32'h8000_0000);
                2:       return coord_t'(0);
                3:       return coord_t'(-1);
                default: return coord_t'(1);
            endcase
        end
        if ($urandom_range(0, 1))
            return coord_t'(32'h7FFF_FFFF) - coord_t'($urandom_range(0, 255));
        return coord_t'(32'h8000_0000) + coord_t'($urandom_range(0, 255));
    endfunction

    // random curve, sometimes clustered around one point
    function automatic curve_t rand_curve();
        curve_t cv;
        coord_t base;
        logic   clustered;
        clustered = ($urandom_range(0, 9) < 2);
        for (int j = 0; j < 3; j++)
        begin
            base = rand_coord();
            for (int k = 0; k < 4; k++)
                cv.ctrl[k][j] = clustered
                    ? base + coord_t'($urandom_range(0, 32'h0001_0000)) - coord_t'(32'h8000)
                    : rand_coord();
        end
        return cv;
    endfunction

    // x gets the values, y their inverse, z the values reversed
    function automatic curve_t mirror_curve(coord_t v0, coord_t v1, coord_t v2, coord_t v3);
        curve_t cv;
        coord_t v[4];
        v = '{v0, v1, v2, v3};
        for (int k = 0; k < 4; k++)
        begin
            cv.ctrl[k][0] = v[k];
            cv.ctrl[k][1] = ~v[k];
            cv.ctrl[k][2] = v[3-k];
        end
        return cv;
    endfunction

    // present a curve and hold it until the transaction completes
    task automatic send_curve(input curve_t cv);
        @(negedge clk);
        start_x  = cv.ctrl[0][0];
        start_y  = cv.ctrl[0][1];
        start_z  = cv.ctrl[0][2];
        near_x   = cv.ctrl[1][0];
        near_y   = cv.ctrl[1][1];
        near_z   = cv.ctrl[1][2];
        far_x    = cv.ctrl[2][0];
        far_y    = cv.ctrl[2][1];
        far_z    = cv.ctrl[2][2];
        end_x    = cv.ctrl[3][0];
        end_y    = cv.ctrl[3][1];
        end_z    = cv.ctrl[3][2];
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_curve(cv);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic feed(input curve_t cv);
        send_curve(cv);
        idle_sender(pick_gap(tx_quiet));
    endtask

    // stop sending until every predicted point has arrived
    task automatic drain_points();
        idle_sender(1);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_segments(input logic [bcfd_pkg::N_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.segments = value;
        settings_used++;
    endtask

    // stimulus
    initial
    begin
        int                         seg_plan[NUM_SETS];
        logic [bcfd_pkg::N_W-1:0]   seg;
        coord_t                     cmax;
        coord_t                     cmin;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        {start_x, start_y, start_z, near_x, near_y, near_z} = '0;
        {far_x, far_y, far_z, end_x, end_y, end_z}         = '0;
        out_stall     = 1'b0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        rx_hold       = 0;
        cycle_count   = 0;
        settings_used = 1;
        cmax          = coord_t'(32'h7FFF_FFFF);
        cmin          = coord_t'(32'h8000_0000);
        seg_plan      = '{0, 1, 63, 2, -1, 16, -1, -1, -1, 63};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed curves at the reset segment count
        feed(mirror_curve(0, 0, 0, 0));
        feed(mirror_curve(cmax, cmax, cmax, cmax));
        feed(mirror_curve(cmin, cmin, cmin, cmin));
        // largest cubic term, wraps the accumulator
        feed(mirror_curve(cmax, cmin, cmax, cmin));
        feed(mirror_curve(cmin, cmax, cmin, cmax));
        feed(mirror_curve(cmin, 0, 0, cmax));
        feed(mirror_curve(cmax, 0, 0, cmin));
        // tiny negative differences, floor rounding
        feed(mirror_curve(0, 1, -1, 0));
        feed(mirror_curve(0, -1, 0, -3));
        feed(mirror_curve(-1, -1, -1, -1));
        feed(mirror_curve(1, 2, 3, 4));
        feed(mirror_curve(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000));
        feed(mirror_curve(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC));
        feed(mirror_curve(cmax, cmax, cmin, cmin));
        for (int i = 0; i < 6; i++)
            feed(rand_curve());

        // random curves over a range of segment counts
        for (int ph = 0; ph < NUM_SETS; ph++)
        begin
            drain_points();
            seg = (seg_plan[ph] < 0) ? bcfd_pkg::N_W'($urandom_range(1, 63))
                                     : bcfd_pkg::N_W'(seg_plan[ph]);
            write_segments(seg);
            tx_quiet = (ph == 3 || ph == 6);
            rx_quiet = (ph == 3 || ph == 6);
            for (int i = 0; i < ITEMS_PER_SET; i++)
            begin
                if ((ph == 1 && i == 10) || $urandom_range(0, 39) == 0)
                    drain_points();
                feed(rand_curve());
            end
        end

        drain_points();
        repeat (150) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d points never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("summary: %0d curves, %0d points checked over %0d segment settings",
                 sb.curves, sb.points, settings_used);
        $display("summary: segment counts 0, 1 and 63 used, with and without idling");
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
